// ----- hdl/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

   localparam int DEPTH_DEFAULT    = 16;
   localparam int TAG_BITS_DEFAULT = 16;
   localparam int OCC_BITS_DEFAULT = $clog2(DEPTH_DEFAULT + 1);
   localparam int LEVEL_BITS       = 4;
   localparam int STATUS_BITS      = 3;

   localparam logic [LEVEL_BITS-1:0] LEVEL_MIN = 4'd1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 4'd10;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_INSERTED = 3'd0,
      ST_SERVED   = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_FULL     = 3'd3,
      ST_INVALID  = 3'd4
   } status_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic                  ins;
      logic                  rem;
      logic [LEVEL_BITS-1:0] level;
   } cmd_type;

endpackage
`default_nettype wire

// ----- hdl/spq_if.sv -----
// Request and response channel interfaces of the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none
interface spq_req_if #(
   parameter int TAG_BITS = spq_pkg::TAG_BITS_DEFAULT
);
   logic                            valid;
   logic                            ready;
   logic                            operation;
   logic [spq_pkg::LEVEL_BITS-1:0]  level;
   logic [TAG_BITS-1:0]             tag;

   modport source (output valid, operation, level, tag, input ready);
   modport sink   (input valid, operation, level, tag, output ready);
endinterface

interface spq_rsp_if #(
   parameter int TAG_BITS = spq_pkg::TAG_BITS_DEFAULT,
   parameter int OCC_BITS = spq_pkg::OCC_BITS_DEFAULT
);
   logic                            valid;
   logic                            ready;
   logic [spq_pkg::STATUS_BITS-1:0] status;
   logic [TAG_BITS-1:0]             served_tag;
   logic [spq_pkg::LEVEL_BITS-1:0]  served_level;
   logic [OCC_BITS-1:0]             occupancy;

   modport source (output valid, status, served_tag, served_level, occupancy, input ready);
   modport sink   (input valid, status, served_tag, served_level, occupancy, output ready);
endinterface
`default_nettype wire

// ----- hdl/spq_cell.sv -----
// One slot of the sorted register chain.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell #(
   parameter int TAG_BITS = spq_pkg::TAG_BITS_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire spq_pkg::cmd_type          cmd,
   input  wire                            prev_ge,
   input  wire [spq_pkg::LEVEL_BITS-1:0]  prev_level,
   input  wire [TAG_BITS-1:0]             prev_tag,
   input  wire [spq_pkg::LEVEL_BITS-1:0]  next_level,
   input  wire [TAG_BITS-1:0]             next_tag,
   input  wire [TAG_BITS-1:0]             new_tag,
   output logic                           ge,
   output logic [spq_pkg::LEVEL_BITS-1:0] level,
   output logic [TAG_BITS-1:0]            tag
);

   logic [spq_pkg::LEVEL_BITS-1:0] level_ff, level_in;
   logic [TAG_BITS-1:0]            tag_ff, tag_in;

   // Level zero marks an empty slot; equal severity stays ahead of the newcomer
   assign ge = (level_ff != '0) && (level_ff >= cmd.level);

   always_comb begin
      level_in = level_ff;
      tag_in   = tag_ff;
      if (cmd.ins && !ge) begin
         if (prev_ge) begin
            level_in = cmd.level;
            tag_in   = new_tag;
         end else begin
            level_in = prev_level;
            tag_in   = prev_tag;
         end
      end else if (cmd.rem) begin
         level_in = next_level;
         tag_in   = next_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
      tag_ff <= tag_in;
   end

   assign level = level_ff;
   assign tag   = tag_ff;

endmodule
`default_nettype wire

// ----- hdl/stable_priority_queue.sv -----
// Top level of the stable priority queue: command decode, cell chain, response register.
`timescale 1ns / 1ps
`default_nettype none
// Bounded priority queue of DEPTH entries kept sorted by descending severity (1 to 10)
// in a chain of cells, slot 0 being the head. An insert transaction places its tag
// behind every held entry of equal or higher severity, so equal severities leave in
// arrival order; a remove transaction returns the head and every cell takes its
// right neighbor. Each request transaction yields exactly one response transaction
// carrying status, the served entry (zero unless served) and the occupancy after the
// operation. Every cell compares against the broadcast severity and shifts in the
// same cycle, so a new request is taken every cycle while the response register is
// empty or being drained; the response register is the only thing that can hold the
// request side back.
module stable_priority_queue #(
   parameter int DEPTH    = spq_pkg::DEPTH_DEFAULT,
   parameter int TAG_BITS = spq_pkg::TAG_BITS_DEFAULT
) (
   input wire         clock,
   input wire         reset,
   spq_req_if.sink    req,
   spq_rsp_if.source  rsp
);

   localparam int OCC_BITS = $clog2(DEPTH + 1);

   logic [OCC_BITS-1:0] count_ff, count_in;

   logic                            rsp_valid_ff;
   spq_pkg::status_type             status_ff, status_in;
   logic [TAG_BITS-1:0]             served_tag_ff, served_tag_in;
   logic [spq_pkg::LEVEL_BITS-1:0]  served_level_ff, served_level_in;
   logic [OCC_BITS-1:0]             occupancy_ff;

   logic                   accept;
   logic                   lvl_bad;
   logic                   full;
   logic                   empty;
   spq_pkg::cmd_type       cmd;

   logic                           ge_w    [DEPTH];
   logic [spq_pkg::LEVEL_BITS-1:0] level_w [DEPTH];
   logic [TAG_BITS-1:0]            tag_w   [DEPTH];

   // Take a new request whenever the response register is free or being emptied
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign lvl_bad = (req.level < spq_pkg::LEVEL_MIN) || (req.level > spq_pkg::LEVEL_MAX);
   assign full    = (count_ff == OCC_BITS'(DEPTH));
   assign empty   = (count_ff == '0);

   // Decode the transaction; the severity check wins over the full check
   always_comb begin
      cmd.ins         = 1'b0;
      cmd.rem         = 1'b0;
      cmd.level       = req.level;
      count_in        = count_ff;
      status_in       = spq_pkg::ST_INSERTED;
      served_tag_in   = '0;
      served_level_in = '0;
      if (req.operation == spq_pkg::OP_INSERT) begin
         if (lvl_bad) begin
            status_in = spq_pkg::ST_INVALID;
         end else if (full) begin
            status_in = spq_pkg::ST_FULL;
         end else begin
            cmd.ins  = accept;
            count_in = count_ff + OCC_BITS'(1);
         end
      end else begin
         if (empty) begin
            status_in = spq_pkg::ST_EMPTY;
         end else begin
            cmd.rem         = accept;
            count_in        = count_ff - OCC_BITS'(1);
            status_in       = spq_pkg::ST_SERVED;
            served_tag_in   = tag_w[0];
            served_level_in = level_w[0];
         end
      end
   end

   // Chain of cells: insert pulls from the left neighbor, remove from the right
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic                           p_ge;
         logic [spq_pkg::LEVEL_BITS-1:0] p_level;
         logic [TAG_BITS-1:0]            p_tag;
         logic [spq_pkg::LEVEL_BITS-1:0] n_level;
         logic [TAG_BITS-1:0]            n_tag;

         if (gi == 0) begin : g_head
            assign p_ge    = 1'b1;
            assign p_level = '0;
            assign p_tag   = '0;
         end else begin : g_body
            assign p_ge    = ge_w[gi-1];
            assign p_level = level_w[gi-1];
            assign p_tag   = tag_w[gi-1];
         end

         // The slot vacated by a remove is cleared
         if (gi == DEPTH - 1) begin : g_tail
            assign n_level = '0;
            assign n_tag   = '0;
         end else begin : g_inner
            assign n_level = level_w[gi+1];
            assign n_tag   = tag_w[gi+1];
         end

         spq_cell #(
            .TAG_BITS (TAG_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .prev_ge    (p_ge),
            .prev_level (p_level),
            .prev_tag   (p_tag),
            .next_level (n_level),
            .next_tag   (n_tag),
            .new_tag    (req.tag),
            .ge         (ge_w[gi]),
            .level      (level_w[gi]),
            .tag        (tag_w[gi])
         );
      end
   endgenerate

   // Hold count and the response register; advance on accept, drop on drain
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         status_ff       <= status_in;
         served_tag_ff   <= served_tag_in;
         served_level_ff <= served_level_in;
         occupancy_ff    <= count_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.served_tag   = served_tag_ff;
   assign rsp.served_level = served_level_ff;
   assign rsp.occupancy    = occupancy_ff;

endmodule
`default_nettype wire
